// ===== hw/rtl/k_transaction_max_profit_defines.svh =====
// Assertion helpers shared by the k_transaction_max_profit RTL.
// Both sample on the rising edge of clk and stay quiet while rst is high.
`ifndef K_TRANSACTION_MAX_PROFIT_DEFINES_SVH
`define K_TRANSACTION_MAX_PROFIT_DEFINES_SVH

// Property that must hold at every sampled edge
`define KMP_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must follow in the cycle after a trigger
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

  localparam int PRICE_W   = 16;
  localparam int PROFIT_W  = 31;
  localparam int VAL_W     = 32;
  localparam int CFG_W     = 5;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int DEF_MAX_K = 16;

  // Register byte addresses
  localparam logic [ADDR_W-1:0] REG_MAX_TRANS = 3'd0;

  localparam logic signed [VAL_W-1:0] HOLD_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [PROFIT_W-1:0]     PROFIT_MAX = {PROFIT_W{1'b1}};

  // What one cell hands to the next every cycle that the row advances
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [PRICE_W-1:0]  price;
    logic [PROFIT_W-1:0] prev_free;  // free value of the level below, before this price
    logic [PROFIT_W-1:0] result;     // profit picked up at the selected level
  } chain_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kmp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "k_transaction_max_profit_defines.svh"

// One transaction level: keeps its holding and free values and passes the
// price on to the next level through its registered forward stage.
module kmp_cell #(
  parameter int INDEX = 0,
  parameter int LW    = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [LW-1:0]    level,
  input  wire kmp_pkg::chain_t  in_stage,
  output kmp_pkg::chain_t       out_stage
);
  import kmp_pkg::*;

  logic signed [VAL_W-1:0] hold;
  logic signed [VAL_W-1:0] hold_next;
  logic [PROFIT_W-1:0]     free;
  logic [PROFIT_W-1:0]     free_next;
  logic signed [VAL_W-1:0] h_cand;
  logic signed [VAL_W:0]   f_sum;
  logic [PROFIT_W-1:0]     f_cand;
  logic                    f_ovf;
  chain_t                  out_next;

  // Level update; free values never go negative so they are kept unsigned
  always_comb begin
    h_cand = $signed({1'b0, in_stage.prev_free})
           - $signed({{(VAL_W-PRICE_W){1'b0}}, in_stage.price});
    f_sum  = $signed({hold[VAL_W-1], hold})
           + $signed({{(VAL_W+1-PRICE_W){1'b0}}, in_stage.price});
    f_ovf  = !f_sum[VAL_W] && f_sum[VAL_W-1];
    f_cand = f_ovf ? PROFIT_MAX : f_sum[PROFIT_W-1:0];
    hold_next = (h_cand > hold) ? h_cand : hold;
    free_next = (!f_sum[VAL_W] && (f_cand > free)) ? f_cand : free;

    out_next           = in_stage;
    out_next.prev_free = free;
    if (level == LW'(INDEX + 1)) begin
      out_next.result = free_next;
    end
  end

  // State and forward stage; a last price returns the level to its start
  always_ff @(posedge clk) begin
    if (rst) begin
      hold            <= HOLD_MIN;
      free            <= '0;
      out_stage.valid <= 1'b0;
    end else if (en) begin
      out_stage <= out_next;
      if (in_stage.valid) begin
        if (in_stage.last) begin
          hold <= HOLD_MIN;
          free <= '0;
        end else begin
          hold <= hold_next;
          free <= free_next;
        end
      end
    end
  end

  `KMP_ASSERT_NEXT(a_clear_after_last, en && in_stage.valid && in_stage.last, hold == HOLD_MIN && free == '0, "level not cleared after last price")

endmodule

`default_nettype wire

// ===== hw/rtl/k_transaction_max_profit.sv =====
// Best profit from at most max_transactions buy-then-sell transactions over a
// price sequence. Prices enter one per cycle on the s_ stream; the profit
// leaves on the m_ stream only for the price marked by s_tlast, after which
// every level starts over for the next sequence. The prices run through a row
// of MAX_K cells, one per transaction level: the first cell loads on the edge
// that takes a price, the price then passes through the forward stage of each
// further cell and then the output register, and a new price can be taken every
// cycle. A stall on m_tready freezes the whole
// row. Levels above MAX_K count as MAX_K; zero gives 0.
// Write max_transactions (byte address 0) only between sequences.
`timescale 1ns / 1ps
`default_nettype none
`include "k_transaction_max_profit_defines.svh"

module k_transaction_max_profit #(
  parameter int MAX_K = kmp_pkg::DEF_MAX_K
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // APB configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [kmp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [kmp_pkg::DATA_W-1:0]   pwdata,
  output logic      [kmp_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  // price stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [kmp_pkg::PRICE_W-1:0]  s_tdata,   // [15:0] price
  input  wire logic                         s_tlast,
  // profit stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [kmp_pkg::DATA_W-1:0]   m_tdata    // [30:0] max_profit, [31] zero
);
  import kmp_pkg::*;

  localparam int LW = $clog2(MAX_K + 1);

  logic [CFG_W-1:0] max_transactions;
  logic [LW-1:0]    level;
  logic             advance;
  chain_t           chain [0:MAX_K];
  chain_t           tail;
  logic             tail_end;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_transactions <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_MAX_TRANS)) begin
      max_transactions <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_MAX_TRANS) begin
      prdata = {{(DATA_W-CFG_W){1'b0}}, max_transactions};
    end
  end

  // Level that supplies the answer, capped at the row length
  assign level = (int'(max_transactions) > MAX_K) ? LW'(MAX_K) : LW'(max_transactions);

  // The row moves whenever the output register can take a result
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_comb begin
    chain[0].valid     = s_tvalid;
    chain[0].last      = s_tlast;
    chain[0].price     = s_tdata;
    chain[0].prev_free = '0;
    chain[0].result    = '0;
  end

  // Row of transaction levels
  for (genvar g = 0; g < MAX_K; g++) begin : g_cell
    kmp_cell #(
      .INDEX (g),
      .LW    (LW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .level     (level),
      .in_stage  (chain[g]),
      .out_stage (chain[g+1])
    );
  end

  assign tail     = chain[MAX_K];
  assign tail_end = tail.valid && tail.last;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= tail_end;
      if (tail_end) begin
        m_tdata <= {{(DATA_W-PROFIT_W){1'b0}}, tail.result};
      end
    end
  end

  `KMP_ASSERT_CLK(a_out_from_tail, $rose(m_tvalid) |-> $past(tail_end), "result without last price")
  `KMP_ASSERT_NEXT(a_stall_freeze, !advance, $stable(tail) && $stable(m_tdata), "row moved in a stall")

endmodule

`default_nettype wire
